### hw/rtl/kedq_pkg.sv
package kedq_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned LeftW = 5;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCodeMinus = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeMiddle = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCodePlus = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeKnob = 2'd3;

  localparam logic [CodeW-1:0] RstCodeMinus = 16'd108;
  localparam logic [CodeW-1:0] RstCodeMiddle = 16'd105;
  localparam logic [CodeW-1:0] RstCodePlus = 16'd106;
  localparam logic [CodeW-1:0] RstCodeKnob = 16'd103;

  localparam logic [CodeW-1:0] EvTypeKey = 16'h0001;
  localparam logic signed [31:0] EvValPress = 32'sd1;
  localparam logic signed [31:0] EvValRelease = 32'sd0;

  // source codes
  localparam logic [1:0] SrcMinus = 2'd0;
  localparam logic [1:0] SrcMiddle = 2'd1;
  localparam logic [1:0] SrcPlus = 2'd2;
  localparam logic [1:0] SrcKnob = 2'd3;

  localparam logic PhaseDown = 1'b0;
  localparam logic PhaseUp = 1'b1;

  typedef struct packed {
    logic [1:0]       source;
    logic             phase;
    logic [TimeW-1:0] time_ms;
  } entry_t;

  // decoded request from the front end to the ring
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cmd_t;

endpackage

### hw/rtl/kedq_filter.sv
module kedq_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                req_type_i,
  input  logic [kedq_pkg::CodeW-1:0]          ev_type_i,
  input  logic [kedq_pkg::CodeW-1:0]          ev_code_i,
  input  logic signed [31:0]                  ev_value_i,
  input  logic [kedq_pkg::TimeW-1:0]          now_ms_i,
  input  logic                                cfg_we_i,
  input  logic [kedq_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [kedq_pkg::CodeW-1:0]          cfg_data_i,
  output kedq_pkg::cmd_t                      cmd_o
);

  logic [kedq_pkg::CodeW-1:0] code_minus_q, code_middle_q, code_plus_q, code_knob_q;

  logic                       vld_q;
  logic                       req_q;
  logic [kedq_pkg::CodeW-1:0] type_q;
  logic [kedq_pkg::CodeW-1:0] code_q;
  logic signed [31:0]         value_q;
  logic [kedq_pkg::TimeW-1:0] now_q;

  logic       is_key;
  logic       is_edge_val;
  logic       hit;
  logic [1:0] src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_minus_q  <= kedq_pkg::RstCodeMinus;
      code_middle_q <= kedq_pkg::RstCodeMiddle;
      code_plus_q   <= kedq_pkg::RstCodePlus;
      code_knob_q   <= kedq_pkg::RstCodeKnob;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kedq_pkg::CfgCodeMinus:  code_minus_q  <= cfg_data_i;
        kedq_pkg::CfgCodeMiddle: code_middle_q <= cfg_data_i;
        kedq_pkg::CfgCodePlus:   code_plus_q   <= cfg_data_i;
        kedq_pkg::CfgCodeKnob:   code_knob_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q   <= req_type_i;
      type_q  <= ev_type_i;
      code_q  <= ev_code_i;
      value_q <= ev_value_i;
      now_q   <= now_ms_i;
    end
  end

  assign is_key      = (type_q == kedq_pkg::EvTypeKey);
  assign is_edge_val = (value_q == kedq_pkg::EvValPress) ||
                       (value_q == kedq_pkg::EvValRelease);

  // first matching register wins on duplicate codes
  always_comb begin
    hit = 1'b1;
    src = kedq_pkg::SrcMinus;
    if (code_q == code_minus_q) begin
      src = kedq_pkg::SrcMinus;
    end else if (code_q == code_middle_q) begin
      src = kedq_pkg::SrcMiddle;
    end else if (code_q == code_plus_q) begin
      src = kedq_pkg::SrcPlus;
    end else if (code_q == code_knob_q) begin
      src = kedq_pkg::SrcKnob;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    cmd_o.push          = vld_q && !req_q && is_key && is_edge_val && hit;
    cmd_o.pop           = vld_q && req_q;
    cmd_o.entry.source  = src;
    cmd_o.entry.phase   = (value_q == kedq_pkg::EvValPress) ? kedq_pkg::PhaseDown
                                                             : kedq_pkg::PhaseUp;
    cmd_o.entry.time_ms = now_q;
  end

endmodule

### hw/rtl/kedq_ring.sv
module kedq_ring #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kedq_pkg::cmd_t               cmd_i,
  output logic                         done_o,
  output logic                         out_valid_o,
  output logic [1:0]                   out_source_o,
  output logic                         out_phase_o,
  output logic [kedq_pkg::TimeW-1:0]   out_time_ms_o,
  output logic [kedq_pkg::LeftW-1:0]   entries_left_o,
  output logic [kedq_pkg::CntW-1:0]    drop_total_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  kedq_pkg::entry_t mem [QUEUE_DEPTH];
  kedq_pkg::entry_t rd_q;

  logic [AW-1:0]               oldest_q, oldest_d, oldest_inc;
  logic [CW-1:0]               fill_q, fill_d, fill_dec;
  logic [kedq_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [AW:0]                 sum;
  logic [AW-1:0]               slot;
  logic                        full;
  logic                        hit;
  logic [CW+kedq_pkg::LeftW-1:0] left_ext;

  logic                        done_q, hit_q;
  logic [kedq_pkg::LeftW-1:0]  left_q;
  logic [kedq_pkg::CntW-1:0]   drop_q;

  assign full       = (fill_q == CW'(QUEUE_DEPTH));
  assign oldest_inc = (oldest_q == AW'(QUEUE_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  assign sum        = {1'b0, oldest_q} + (AW + 1)'(fill_q);
  assign hit        = cmd_i.pop && (fill_q != '0);
  assign fill_dec   = fill_q - CW'(1);
  assign left_ext   = {{kedq_pkg::LeftW{1'b0}}, fill_dec};

  always_comb begin
    // when full the new word lands on the oldest slot
    if (full) begin
      slot = oldest_q;
    end else if (sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      slot = AW'(sum - (AW + 1)'(QUEUE_DEPTH));
    end else begin
      slot = sum[AW-1:0];
    end
  end

  always_comb begin
    oldest_d = oldest_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    if (cmd_i.push) begin
      if (full) begin
        oldest_d = oldest_inc;
        if (cnt_q != '1) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end else if (hit) begin
      oldest_d = oldest_inc;
      fill_d   = fill_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      left_q   <= '0;
      drop_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      done_q   <= cmd_i.pop;
      hit_q    <= hit;
      left_q   <= hit ? left_ext[kedq_pkg::LeftW-1:0] : '0;
      drop_q   <= cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[slot] <= cmd_i.entry;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[oldest_q];
    end
  end

  assign done_o         = done_q;
  assign out_valid_o    = hit_q;
  assign out_source_o   = hit_q ? rd_q.source : 2'd0;
  assign out_phase_o    = hit_q & rd_q.phase;
  assign out_time_ms_o  = hit_q ? rd_q.time_ms : '0;
  assign entries_left_o = left_q;
  assign drop_total_o   = drop_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_valid_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> done_o)
    else $error("valid word without strobe");

  a_empty_left_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_q |-> (left_q == '0))
    else $error("entries left nonzero on empty pop");

  a_overwrite_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && full && cnt_q != '1) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("overwrite not counted");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> (fill_q == $past(fill_q) - 1'b1))
    else $error("pop did not shrink the queue");

endmodule

### hw/rtl/key_event_drop_oldest_queue_core.sv
// Key event queue with drop-oldest overflow.
//
// Command channel: raise start_i with the request fields for one cycle per
// word. busy_o stays low, so a word is taken on every cycle that start_i is
// high. req_type_i = 0 offers a raw event: it is queued when it is a key
// press or release whose code matches one of the four code registers.
// req_type_i = 1 pops the oldest entry.
// Every pop gives one result word, marked by done_o for a single cycle, after
// the input register and then the ring update and registered entry read. A
// raw event gives no result. Throughput is one word per cycle.
// The receiver cannot stall: a result must be taken while done_o is high.
// When the ring is full a new entry overwrites the oldest one and
// drop_total_o counts up, saturating at all ones. Code registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only
// while the queue is idle, as the block does not enforce it. Reset empties
// the queue, clears the drop count and loads the default codes; entry
// memory itself is not cleared.
module key_event_drop_oldest_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               req_type_i,
  input  logic [kedq_pkg::CodeW-1:0]         ev_type_i,
  input  logic [kedq_pkg::CodeW-1:0]         ev_code_i,
  input  logic signed [31:0]                 ev_value_i,
  input  logic [kedq_pkg::TimeW-1:0]         now_ms_i,
  input  logic                               cfg_we_i,
  input  logic [kedq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kedq_pkg::CodeW-1:0]         cfg_data_i,
  output logic                               done_o,
  output logic                               out_valid_o,
  output logic [1:0]                         out_source_o,
  output logic                               out_phase_o,
  output logic [kedq_pkg::TimeW-1:0]         out_time_ms_o,
  output logic [kedq_pkg::LeftW-1:0]         entries_left_o,
  output logic [kedq_pkg::CntW-1:0]          drop_total_o
);

  kedq_pkg::cmd_t cmd;

  // one word per cycle, never held off
  assign busy_o = 1'b0;

  kedq_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .ev_type_i  (ev_type_i),
    .ev_code_i  (ev_code_i),
    .ev_value_i (ev_value_i),
    .now_ms_i   (now_ms_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd)
  );

  kedq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .done_o         (done_o),
    .out_valid_o    (out_valid_o),
    .out_source_o   (out_source_o),
    .out_phase_o    (out_phase_o),
    .out_time_ms_o  (out_time_ms_o),
    .entries_left_o (entries_left_o),
    .drop_total_o   (drop_total_o)
  );

endmodule
